/* rtl/irmt_pkg.sv */
package irmt_pkg;

    localparam int ID_W = 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // one stored inclusive range
    typedef struct packed {
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
    } range_t;

    // query token walking down the cell row
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] probe;
        logic            hit;
    } token_t;

endpackage

/* rtl/irmt_cell.sv */
module irmt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  irmt_pkg::range_t range_in,
    output irmt_pkg::range_t range_out,
    input  logic [CW-1:0]   count,
    input  irmt_pkg::token_t tok_in,
    output irmt_pkg::token_t tok_out
);
    import irmt_pkg::*;

    range_t          range_reg;
    logic            tok_valid_reg;
    logic [ID_W-1:0] tok_probe_reg;
    logic            tok_hit_reg;
    logic            held;
    logic            match;

    // entries sit in cells 0..count-1, newest in cell 0
    assign held  = count > CW'(IDX);
    assign match = held && (range_reg.lo <= tok_in.probe) && (tok_in.probe <= range_reg.hi);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            range_reg <= range_in;
        end
        tok_probe_reg <= tok_in.probe;
        tok_hit_reg   <= tok_in.hit | match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    assign range_out     = range_reg;
    assign tok_out.valid = tok_valid_reg;
    assign tok_out.probe = tok_probe_reg;
    assign tok_out.hit   = tok_hit_reg;

endmodule

/* rtl/id_range_membership_table_unit.sv */
// Add, clear and unknown ops: done strobes in the cycle after accept; busy stays low,
// so a new item can be taken in the strobe cycle.
// Query: the probe walks one range cell per cycle; busy is then high until the token
// leaves the last cell; the result strobes as busy falls. The cell row sets this delay.
// Reset clears the entry count, busy and the strobe; stored ranges are not cleared.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module id_range_membership_table_unit #(
    parameter int MAX_RANGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] range_low,
    input  logic [31:0] range_high,
    input  logic [31:0] probe_id,
    output logic        done,
    output logic [1:0]  status,
    output logic        hit,
    output logic        is_empty,
    output logic [4:0]  entries
);
    import irmt_pkg::*;

    // count must hold MAX_RANGES itself
    localparam int CW = $clog2(MAX_RANGES + 1);

    logic          accept;
    logic          shift_en;
    range_t        new_range;
    range_t        range_chain [0:MAX_RANGES-1];
    token_t        tok_chain   [0:MAX_RANGES];

    logic [CW-1:0] count_reg,  count_next;
    logic          busy_reg,   busy_next;
    logic          done_reg,   done_next;
    status_t       status_reg, status_next;
    logic          hit_reg,    hit_next;

    assign accept       = start && !busy_reg;
    assign new_range.lo = range_low;
    assign new_range.hi = range_high;

    // a query token enters cell 0 straight from the ports
    assign tok_chain[0].valid = accept && (op == OP_QUERY);
    assign tok_chain[0].probe = probe_id;
    assign tok_chain[0].hit   = 1'b0;

    // a new range enters cell 0; older ones shift one cell down the row
    assign range_chain[0] = new_range;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            if (gi < MAX_RANGES - 1)
            begin : g_mid
                irmt_cell #(
                    .IDX (gi),
                    .CW  (CW)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (shift_en),
                    .range_in  (range_chain[gi]),
                    .range_out (range_chain[gi+1]),
                    .count     (count_reg),
                    .tok_in    (tok_chain[gi]),
                    .tok_out   (tok_chain[gi+1])
                );
            end
            else
            begin : g_last
                // last cell: its range drops off the end of the row
                irmt_cell #(
                    .IDX (gi),
                    .CW  (CW)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .shift_en  (shift_en),
                    .range_in  (range_chain[gi]),
                    .range_out (),
                    .count     (count_reg),
                    .tok_in    (tok_chain[gi]),
                    .tok_out   (tok_chain[gi+1])
                );
            end
        end
    endgenerate

    // control: one item at a time, results go out through registers
    always_comb
    begin
        count_next  = count_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        hit_next    = 1'b0;
        shift_en    = 1'b0;

        // query token fell out of the last cell
        if (tok_chain[MAX_RANGES].valid)
        begin
            done_next = 1'b1;
            hit_next  = tok_chain[MAX_RANGES].hit;
            busy_next = 1'b0;
        end

        if (accept)
        begin
            unique case (op_t'(op))
                OP_ADD:
                begin
                    done_next = 1'b1;
                    if (range_low > range_high)
                    begin
                        status_next = ST_INVALID;
                    end
                    else if (count_reg == CW'(MAX_RANGES))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        shift_en   = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_QUERY:
                begin
                    busy_next = 1'b1;
                end
                OP_CLEAR:
                begin
                    done_next  = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    // reserved op: report state unchanged
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            hit_reg    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign status   = status_reg;
    assign hit      = hit_reg;
    // count is stable from the strobe on until the next accepted item lands
    assign is_empty = (count_reg == '0);
    assign entries  = 5'(count_reg);

endmodule

/* rtl/irmt_checker.sv */
module irmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic        hit,
    input logic        is_empty,
    input logic [4:0]  entries
);
    import irmt_pkg::*;

    // an accepted item either strobes next cycle or holds the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither finished nor pending");

    // no result while a query is still walking the row
    a_busy_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobed while busy");

    // hit only appears on a successful result
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (done && status == ST_OK))
        else $error("hit outside an ok result");

    // refused adds leave the table untouched
    a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_INVALID || status == ST_FULL)) |->
            ($stable(entries) && $stable(is_empty)))
        else $error("refused add changed the table");

endmodule

bind id_range_membership_table_unit irmt_checker u_irmt_checker (.*);
